@@ rtl/core/kmsd_pkg.sv @@
// kmsd_pkg: sizes, types and helper functions of the keypad matrix scanner.
// Used by the scanner top level.
`default_nettype none

package kmsd_pkg;

   localparam int NUM_ROWS = 8;
   localparam int NUM_COLS = 8;
   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int COL_W    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
   // only eight columns are sampled per row
   localparam int LANES    = (NUM_COLS < 8) ? NUM_COLS : 8;
   localparam int CNT_W    = 8;

   localparam logic [7:0]       ROW_DRIVE_ONE  = 8'h01;
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd8;

   typedef logic [ROW_W-1:0]          row_idx_type;
   typedef logic [COL_W-1:0]          col_idx_type;
   // stable levels in the upper half, raw levels in the lower half
   typedef logic [2*NUM_COLS-1:0]     lvl_row_type;
   typedef logic [NUM_COLS*CNT_W-1:0] cnt_row_type;

   function automatic row_idx_type next_row(input row_idx_type r);
      row_idx_type n;
      if (r == row_idx_type'(NUM_ROWS - 1)) begin
         n = '0;
      end else begin
         n = r + row_idx_type'(1);
      end
      return n;
   endfunction

   // one-hot drive, zero for rows that do not fit in eight bits
   function automatic logic [7:0] row_drive(input row_idx_type r);
      logic [7:0] d;
      d = ROW_DRIVE_ONE << r;
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/kmsd_req_if.sv @@
// kmsd_req_if: row sample channel (column levels plus key query).
// Depends on nothing; field widths are those of the channel.
`default_nettype none

interface kmsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] column_levels;
   logic [2:0] query_row;
   logic [2:0] query_col;

   modport source (output valid, output column_levels, output query_row,
                   output query_col, input ready);
   modport sink   (input valid, input column_levels, input query_row,
                   input query_col, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kmsd_rsp_if.sv @@
// kmsd_rsp_if: scan result channel (row, drive, presses, query answer).
// Depends on nothing; field widths are those of the channel.
`default_nettype none

interface kmsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] scanned_row;
   logic [7:0] next_row_drive;
   logic [7:0] press_row_onehot;
   logic [7:0] press_columns;
   logic       queried_key_state;

   modport source (output valid, output scanned_row, output next_row_drive,
                   output press_row_onehot, output press_columns,
                   output queried_key_state, input ready);
   modport sink   (input valid, input scanned_row, input next_row_drive,
                   input press_row_onehot, input press_columns,
                   input queried_key_state, output ready);
endinterface

`default_nettype wire

@@ rtl/core/keypad_matrix_scan_debounce.sv @@
// keypad_matrix_scan_debounce: 8x8 key matrix scanner with per-key debounce.
// Depends on kmsd_pkg, kmsd_req_if and kmsd_rsp_if.
//
//   channel    dir   handshake            carries
//   req_chan   in    valid/ready          column_levels, query_row, query_col
//   rsp_chan   out   valid/ready          row, drive, press mask, query answer
//   csr_*      in    write enable only    settle threshold
//
// One transaction per cycle sustained while the response is not stalled; from
// acceptance a response passes the row memory read, then update plus output register.
// Key state sits in two row-wide memories (levels, counts) read on accept and
// written back when the update stage advances; same-row overlap is forwarded.
// Reset clears the row pointer, per-row valid bits and handshake state; rows
// never written read as released with zero count.
// A stalled response holds the update stage; one new transaction may still
// enter while the response register is full and the update stage is empty.
`default_nettype none

module keypad_matrix_scan_debounce (
   input  wire logic        clock,
   input  wire logic        reset,
   kmsd_req_if.sink         req_chan,
   kmsd_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data
);

   // configuration
   logic [kmsd_pkg::CNT_W-1:0] thresh_ff;

   // handshake and row pointer
   kmsd_pkg::row_idx_type row_ptr_ff;
   logic                  s1_valid_ff;
   logic                  out_valid_ff;
   logic                  out_free;
   logic                  s1_adv;
   logic                  accept;

   // update stage payload
   kmsd_pkg::row_idx_type s1_row_ff;
   logic [7:0]            s1_levels_ff;
   kmsd_pkg::row_idx_type s1_qrow_ff;
   kmsd_pkg::col_idx_type s1_qcol_ff;
   logic                  s1_qin_ff;

   // memories and their read side
   kmsd_pkg::lvl_row_type lvl_mem [kmsd_pkg::NUM_ROWS];
   kmsd_pkg::cnt_row_type cnt_mem [kmsd_pkg::NUM_ROWS];
   logic [kmsd_pkg::NUM_ROWS-1:0] row_vld_ff;
   kmsd_pkg::lvl_row_type lvl_rd_ff;
   kmsd_pkg::cnt_row_type cnt_rd_ff;
   kmsd_pkg::lvl_row_type qlvl_rd_ff;
   logic                  rd_vld_ff;
   logic                  qrd_vld_ff;

   // forwarding of the row written on the read edge
   logic                  fwd_hit_ff;
   kmsd_pkg::lvl_row_type fwd_lvl_ff;
   kmsd_pkg::cnt_row_type fwd_cnt_ff;
   logic                  qfwd_hit_ff;
   kmsd_pkg::lvl_row_type qfwd_lvl_ff;

   // request side addresses
   kmsd_pkg::row_idx_type q_addr;
   logic                  q_inrange;

   // update logic
   kmsd_pkg::lvl_row_type cur_lvl;
   kmsd_pkg::cnt_row_type cur_cnt;
   kmsd_pkg::lvl_row_type new_lvl;
   kmsd_pkg::cnt_row_type new_cnt;
   logic [7:0]            press;
   logic                  q_state;

   // output register
   logic [2:0] out_row_ff;
   logic [7:0] out_drive_ff;
   logic [7:0] out_prow_ff;
   logic [7:0] out_pcol_ff;
   logic       out_q_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept   = req_chan.valid && req_chan.ready;

   assign q_addr    = kmsd_pkg::row_idx_type'(req_chan.query_row);
   assign q_inrange = (int'(req_chan.query_row) < kmsd_pkg::NUM_ROWS) &&
                      (int'(req_chan.query_col) < kmsd_pkg::NUM_COLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= kmsd_pkg::DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ptr_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         if (accept) begin
            row_ptr_ff <= kmsd_pkg::next_row(row_ptr_ff);
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff          <= 1'b1;
            row_vld_ff[s1_row_ff] <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // memory write-back of the updated row
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         lvl_mem[s1_row_ff] <= new_lvl;
         cnt_mem[s1_row_ff] <= new_cnt;
      end
   end

   // memory reads for the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         lvl_rd_ff  <= lvl_mem[row_ptr_ff];
         cnt_rd_ff  <= cnt_mem[row_ptr_ff];
         qlvl_rd_ff <= lvl_mem[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_vld_ff    <= row_vld_ff[row_ptr_ff];
         qrd_vld_ff   <= row_vld_ff[q_addr];
         fwd_hit_ff   <= s1_adv && (s1_row_ff == row_ptr_ff);
         fwd_lvl_ff   <= new_lvl;
         fwd_cnt_ff   <= new_cnt;
         qfwd_hit_ff  <= s1_adv && (s1_row_ff == q_addr);
         qfwd_lvl_ff  <= new_lvl;
         s1_row_ff    <= row_ptr_ff;
         s1_levels_ff <= req_chan.column_levels;
         s1_qrow_ff   <= q_addr;
         s1_qcol_ff   <= kmsd_pkg::col_idx_type'(req_chan.query_col);
         s1_qin_ff    <= q_inrange;
      end
   end

   always_comb begin
      priority if (fwd_hit_ff) begin
         cur_lvl = fwd_lvl_ff;
         cur_cnt = fwd_cnt_ff;
      end else if (rd_vld_ff) begin
         cur_lvl = lvl_rd_ff;
         cur_cnt = cnt_rd_ff;
      end else begin
         cur_lvl = '0;
         cur_cnt = '0;
      end
   end

   // all keys of the row side by side
   always_comb begin
      logic                       p;
      logic [kmsd_pkg::CNT_W-1:0] cnt;
      new_lvl = cur_lvl;
      new_cnt = cur_cnt;
      press   = '0;
      for (int c = 0; c < kmsd_pkg::LANES; c++) begin
         p   = !s1_levels_ff[c];
         cnt = cur_cnt[c*kmsd_pkg::CNT_W +: kmsd_pkg::CNT_W];
         if (p != cur_lvl[c]) begin
            new_lvl[c] = p;
            new_cnt[c*kmsd_pkg::CNT_W +: kmsd_pkg::CNT_W] = '0;
         end else if (cnt >= thresh_ff) begin
            press[c] = p && !cur_lvl[kmsd_pkg::NUM_COLS + c];
            new_lvl[kmsd_pkg::NUM_COLS + c] = p;
         end else begin
            new_cnt[c*kmsd_pkg::CNT_W +: kmsd_pkg::CNT_W] =
               cnt + kmsd_pkg::CNT_W'(1);
         end
      end
   end

   // query sees the stable levels after this update
   always_comb begin
      priority if (!s1_qin_ff) begin
         q_state = 1'b0;
      end else if (s1_qrow_ff == s1_row_ff) begin
         q_state = new_lvl[kmsd_pkg::NUM_COLS + int'(s1_qcol_ff)];
      end else if (qfwd_hit_ff) begin
         q_state = qfwd_lvl_ff[kmsd_pkg::NUM_COLS + int'(s1_qcol_ff)];
      end else if (qrd_vld_ff) begin
         q_state = qlvl_rd_ff[kmsd_pkg::NUM_COLS + int'(s1_qcol_ff)];
      end else begin
         q_state = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_row_ff   <= 3'(s1_row_ff);
         out_drive_ff <= kmsd_pkg::row_drive(kmsd_pkg::next_row(s1_row_ff));
         out_prow_ff  <= (press != '0) ? kmsd_pkg::row_drive(s1_row_ff) : '0;
         out_pcol_ff  <= press;
         out_q_ff     <= q_state;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.scanned_row       = out_row_ff;
   assign rsp_chan.next_row_drive    = out_drive_ff;
   assign rsp_chan.press_row_onehot  = out_prow_ff;
   assign rsp_chan.press_columns     = out_pcol_ff;
   assign rsp_chan.queried_key_state = out_q_ff;

endmodule

`default_nettype wire

@@ rtl/core/kmsd_checker.sv @@
// kmsd_checker: port-level assertions for the keypad scanner, bound to the top.
// Depends on keypad_matrix_scan_debounce and its channel interfaces.
`default_nettype none

module kmsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_scanned_row,
   input wire logic [7:0] rsp_next_row_drive,
   input wire logic [7:0] rsp_press_row_onehot,
   input wire logic [7:0] rsp_press_columns,
   input wire logic       rsp_queried_key_state
);

   // row flag and column mask agree
   a_press_row_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_press_row_onehot != 8'd0) == (rsp_press_columns != 8'd0)))
      else $error("press row flag disagrees with press columns");

   // flagged row is the scanned row
   a_press_row_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_press_columns != 8'd0) |->
         rsp_press_row_onehot == (8'd1 << rsp_scanned_row))
      else $error("press row is not the scanned row");

   // drive points to the row after the scanned one
   a_next_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_row_drive == (8'd1 << 3'(rsp_scanned_row + 3'd1)))
      else $error("next row drive does not follow scanned row");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scanned_row) &&
         $stable(rsp_press_columns) && $stable(rsp_queried_key_state))
      else $error("stalled response changed");

endmodule

bind keypad_matrix_scan_debounce kmsd_checker u_kmsd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_scanned_row       (rsp_chan.scanned_row),
   .rsp_next_row_drive    (rsp_chan.next_row_drive),
   .rsp_press_row_onehot  (rsp_chan.press_row_onehot),
   .rsp_press_columns     (rsp_chan.press_columns),
   .rsp_queried_key_state (rsp_chan.queried_key_state)
);

`default_nettype wire
